@@ design/swpf_pkg.sv @@
// Package for the staleness-weighted position fusion block.
// Holds default widths, count constants and the divider lane control struct.
// No dependencies.
package swpf_pkg;

    localparam int SWPF_COORD_WIDTH = 32;
    localparam int SWPF_FRAC_BITS   = 16;
    localparam int SWPF_CNT_W       = 6;
    localparam int SWPF_PREV_INT    = 10000;

    typedef logic [SWPF_CNT_W-1:0] t_cnt;

    localparam t_cnt SWPF_CAP_RESET = 6'd31;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic fin1;
        logic fin2;
    } t_lane_ctl;

endpackage

@@ design/swpf_in_if.sv @@
// Input channel of the fusion block: radar and laser position per item.
// Depends on nothing; width set by COORD_WIDTH.
interface swpf_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] radar_x;
    logic signed [COORD_WIDTH-1:0] radar_y;
    logic signed [COORD_WIDTH-1:0] laser_x;
    logic signed [COORD_WIDTH-1:0] laser_y;

    modport source (output valid, output radar_x, output radar_y, output laser_x,
                    output laser_y, input ready);
    modport sink   (input valid, input radar_x, input radar_y, input laser_x,
                    input laser_y, output ready);
endinterface

@@ design/swpf_out_if.sv @@
// Output channel of the fusion block: fused and switched positions, counts.
// Depends on nothing; width set by COORD_WIDTH.
interface swpf_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] fused_x;
    logic signed [COORD_WIDTH-1:0] fused_y;
    logic signed [COORD_WIDTH-1:0] switched_x;
    logic signed [COORD_WIDTH-1:0] switched_y;
    logic        [5:0]             radar_stale;
    logic        [5:0]             laser_stale;

    modport source (output valid, output fused_x, output fused_y, output switched_x,
                    output switched_y, output radar_stale, output laser_stale,
                    input ready);
    modport sink   (input valid, input fused_x, input fused_y, input switched_x,
                    input switched_y, input radar_stale, input laser_stale,
                    output ready);
endinterface

@@ design/swpf_stale.sv @@
// Repeat tracker: previous positions, saturating repeat counts, cap register.
// Depends on swpf_pkg.
module swpf_stale
    import swpf_pkg::*;
#(
    parameter int COORD_WIDTH = SWPF_COORD_WIDTH,
    parameter int FRAC_BITS   = SWPF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cnt                   i_cfg_wdata,
    input  logic                   i_upd,
    input  logic [COORD_WIDTH-1:0] i_rx,
    input  logic [COORD_WIDTH-1:0] i_ry,
    input  logic [COORD_WIDTH-1:0] i_lx,
    input  logic [COORD_WIDTH-1:0] i_ly,
    output t_cnt                   o_radar_cnt,
    output t_cnt                   o_laser_cnt
);

    localparam logic [COORD_WIDTH-1:0] PREV_RST =
        COORD_WIDTH'(64'(SWPF_PREV_INT) << FRAC_BITS);

    logic [COORD_WIDTH-1:0] r_prx, r_pry, r_plx, r_ply;
    t_cnt                   r_cap, r_rc, r_lc;
    t_cnt                   n_rc, n_lc;
    logic                   rep_r, rep_l;

    always_comb begin
        rep_r = (i_rx == r_prx) && (i_ry == r_pry);
        rep_l = (i_lx == r_plx) && (i_ly == r_ply);
        if (!rep_r) begin
            n_rc = '0;
        end else if (r_rc >= r_cap) begin
            n_rc = r_cap;
        end else begin
            n_rc = r_rc + t_cnt'(1);
        end
        if (!rep_l) begin
            n_lc = '0;
        end else if (r_lc >= r_cap) begin
            n_lc = r_cap;
        end else begin
            n_lc = r_lc + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= SWPF_CAP_RESET;
            r_rc  <= '0;
            r_lc  <= '0;
            r_prx <= PREV_RST;
            r_pry <= PREV_RST;
            r_plx <= PREV_RST;
            r_ply <= PREV_RST;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_upd) begin
                r_rc  <= n_rc;
                r_lc  <= n_lc;
                r_prx <= i_rx;
                r_pry <= i_ry;
                r_plx <= i_lx;
                r_ply <= i_ly;
            end
        end
    end

    assign o_radar_cnt = r_rc;
    assign o_laser_cnt = r_lc;

endmodule

@@ design/swpf_lane.sv @@
// One coordinate lane: weighted mean by a bit-serial restoring divider.
// Depends on swpf_pkg; sequenced by the top level through t_lane_ctl.
module swpf_lane
    import swpf_pkg::*;
#(
    parameter int COORD_WIDTH = SWPF_COORD_WIDTH
) (
    input  logic                   i_clk,
    input  t_lane_ctl              i_ctl,
    input  logic [COORD_WIDTH-1:0] i_fresh,
    input  logic [COORD_WIDTH-1:0] i_stale,
    input  t_cnt                   i_d,
    output logic [COORD_WIDTH-1:0] o_result
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 1;
    localparam int DW = CW + 3;
    localparam int QW = CW + 2;
    localparam int SW = $clog2(DW);

    logic [CW-1:0] r_fresh, r_res;
    logic [NW-1:0] r_diff, r_nq;
    logic [DW-1:0] r_den, r_rem;
    logic [QW-1:0] r_s;
    logic          r_neg, r_nz;

    logic [SW-1:0] dc;
    logic [DW-1:0] n_den;
    logic [NW-1:0] n_diff;
    logic [DW:0]   sh, sub;
    logic          ge;
    logic [QW-1:0] fresh_q, n_s;

    always_comb begin
        dc      = (int'(i_d) > CW + 2) ? SW'(CW + 2) : i_d[SW-1:0];
        n_den   = (DW'(1) << dc) + DW'(1);
        n_diff  = {i_stale[CW-1], i_stale} - {i_fresh[CW-1], i_fresh};
        sh      = {r_rem, r_nq[NW-1]};
        sub     = sh - {1'b0, r_den};
        ge      = sh >= {1'b0, r_den};
        fresh_q = {{2{r_fresh[CW-1]}}, r_fresh};
        if (r_neg) begin
            n_s = fresh_q + ~{1'b0, r_nq} + QW'(!(|r_rem));
        end else begin
            n_s = fresh_q + {1'b0, r_nq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_fresh <= i_fresh;
            r_diff  <= n_diff;
            r_den   <= n_den;
        end
        if (i_ctl.prep) begin
            r_neg <= r_diff[NW-1];
            r_nq  <= r_diff[NW-1] ? (NW'(0) - r_diff) : r_diff;
            r_rem <= '0;
        end
        if (i_ctl.step) begin
            r_rem <= ge ? sub[DW-1:0] : sh[DW-1:0];
            r_nq  <= {r_nq[NW-2:0], ge};
        end
        if (i_ctl.fin1) begin
            r_s  <= n_s;
            r_nz <= |r_rem;
        end
        if (i_ctl.fin2) begin
            r_res <= (r_s[QW-1] && r_nz) ? CW'(r_s + QW'(1)) : r_s[CW-1:0];
        end
    end

    assign o_result = r_res;

endmodule

@@ design/staleness_weighted_position_fusion.sv @@
// Staleness-weighted radar/laser position fusion, one item at a time.
// A new item is accepted only in the idle state, after the last result has moved
// to the output register; the divider lanes produce one quotient bit per cycle.
// Result waits in an output register.
// Reset (synchronous, active low): cap 31, counts 0, previous positions 10000.0.
module staleness_weighted_position_fusion
    import swpf_pkg::*;
#(
    parameter int COORD_WIDTH = SWPF_COORD_WIDTH,
    parameter int FRAC_BITS   = SWPF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    swpf_in_if.sink     i_in,
    swpf_out_if.source  o_out
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 1;
    localparam int BW = $clog2(NW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN1 = 3'd4;
    localparam logic [2:0] S_FIN2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_rx, r_ry, r_lx, r_ly, r_swx, r_swy;
    logic [CW-1:0] r_fx, r_fy, r_osx, r_osy;
    t_cnt          r_ors, r_ols;
    logic          r_ovalid;

    logic          acc, load_out;
    t_cnt          rc, lc, d;
    logic          radar_le;
    t_lane_ctl     ctl;
    logic [CW-1:0] fx, fy, fr_x, fr_y, st_x, st_y;

    assign acc      = i_in.valid && i_in.ready;
    assign load_out = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    swpf_stale #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_stale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_upd       (acc),
        .i_rx        (i_in.radar_x),
        .i_ry        (i_in.radar_y),
        .i_lx        (i_in.laser_x),
        .i_ly        (i_in.laser_y),
        .o_radar_cnt (rc),
        .o_laser_cnt (lc)
    );

    always_comb begin
        radar_le = rc <= lc;
        d        = radar_le ? (lc - rc) : (rc - lc);
        fr_x     = radar_le ? r_rx : r_lx;
        fr_y     = radar_le ? r_ry : r_ly;
        st_x     = radar_le ? r_lx : r_rx;
        st_y     = radar_le ? r_ly : r_ry;
        ctl.load = r_state == S_LOAD;
        ctl.prep = r_state == S_PREP;
        ctl.step = r_state == S_DIV;
        ctl.fin1 = r_state == S_FIN1;
        ctl.fin2 = r_state == S_FIN2;
    end

    swpf_lane #(.COORD_WIDTH (COORD_WIDTH)) u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fresh  (fr_x),
        .i_stale  (st_x),
        .i_d      (d),
        .o_result (fx)
    );

    swpf_lane #(.COORD_WIDTH (COORD_WIDTH)) u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fresh  (fr_y),
        .i_stale  (st_y),
        .i_d      (d),
        .o_result (fy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc) n_state = S_LOAD;
            S_LOAD:  n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_bit == BW'(NW - 1)) n_state = S_FIN1;
            S_FIN1:  n_state = S_FIN2;
            S_FIN2:  n_state = S_OUT;
            S_OUT:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bit    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_bit <= r_bit + BW'(1);
            end else begin
                r_bit <= '0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rx <= i_in.radar_x;
            r_ry <= i_in.radar_y;
            r_lx <= i_in.laser_x;
            r_ly <= i_in.laser_y;
        end
        if (r_state == S_LOAD) begin
            r_swx <= (rc < lc) ? r_rx : r_lx;
            r_swy <= (rc < lc) ? r_ry : r_ly;
        end
        if (load_out) begin
            r_fx  <= fx;
            r_fy  <= fy;
            r_osx <= r_swx;
            r_osy <= r_swy;
            r_ors <= rc;
            r_ols <= lc;
        end
    end

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_ovalid;
    assign o_out.fused_x     = r_fx;
    assign o_out.fused_y     = r_fy;
    assign o_out.switched_x  = r_osx;
    assign o_out.switched_y  = r_osy;
    assign o_out.radar_stale = r_ors;
    assign o_out.laser_stale = r_ols;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !i_in.ready)
        else $error("item accepted while another is in flight");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bit < BW'(NW)))
        else $error("divider ran past its quotient width");

    a_rose_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_OUT))
        else $error("result shown without finishing an item");

    a_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |->
            ((($signed(r_fx) >= $signed(r_rx)) && ($signed(r_fx) <= $signed(r_lx))) ||
             (($signed(r_fx) >= $signed(r_lx)) && ($signed(r_fx) <= $signed(r_rx)))))
        else $error("fused x outside the two sensor positions");

endmodule

@@ dv/tb_staleness_weighted_position_fusion.sv @@
// Testbench for staleness_weighted_position_fusion: directed table, then random runs of
// repeated and fresh sensor positions under several stale caps, checked against a predictor.
// Depends on swpf_pkg, swpf_in_if, swpf_out_if and the fusion block.
module tb_staleness_weighted_position_fusion
    import swpf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = SWPF_COORD_WIDTH;
    localparam int PHASE_N     = 10;
    localparam int PHASE_ITEMS = 63;
    localparam int ROW_N       = 21;
    localparam int QUIET_LIMIT = 2000;
    localparam int SINK_HOLD   = 150;

    localparam logic signed [CW-1:0] HOME = CW'(64'(SWPF_PREV_INT) << SWPF_FRAC_BITS);
    localparam logic signed [CW-1:0] TOP  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] BOT  = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] radar_x;
        logic signed [CW-1:0] radar_y;
        logic signed [CW-1:0] laser_x;
        logic signed [CW-1:0] laser_y;
    } t_pair;

    typedef struct packed {
        logic signed [CW-1:0] fused_x;
        logic signed [CW-1:0] fused_y;
        logic signed [CW-1:0] switched_x;
        logic signed [CW-1:0] switched_y;
        t_cnt                 radar_stale;
        t_cnt                 laser_stale;
    } t_fusion;

    typedef struct packed {
        t_pair   pair;
        logic    typed;
        t_fusion want;
    } t_row;

    localparam t_row DIRECTED [ROW_N] = '{
        '{'{HOME, HOME, HOME, HOME}, 1'b1, '{HOME, HOME, HOME, HOME, 6'd1, 6'd1}},
        '{'{TOP, TOP, BOT, BOT},     1'b1, '{0, 0, BOT, BOT, 6'd0, 6'd0}},
        '{'{TOP, TOP, BOT, BOT},     1'b1, '{0, 0, BOT, BOT, 6'd1, 6'd1}},
        '{'{TOP, TOP, BOT, BOT},     1'b1, '{0, 0, BOT, BOT, 6'd2, 6'd2}},
        '{'{TOP, BOT, BOT, BOT},     1'b0, '0},
        '{'{BOT, BOT, BOT, BOT},     1'b1, '{BOT, BOT, BOT, BOT, 6'd0, 6'd4}},
        '{'{0, 0, -1, -1},           1'b1, '{0, 0, -1, -1, 6'd0, 6'd0}},
        '{'{0, 0, -1, -1},           1'b1, '{0, 0, -1, -1, 6'd1, 6'd1}},
        '{'{-3, -3, 0, 0},           1'b1, '{-1, -1, 0, 0, 6'd0, 6'd0}},
        '{'{3, -3, -4, 4},           1'b1, '{0, 0, -4, 4, 6'd0, 6'd0}},
        '{'{3, -3, TOP, 0},          1'b0, '0},
        '{'{3, -3, BOT, HOME},       1'b0, '0},
        '{'{3, -3, 32'h4000_0000, -1}, 1'b0, '0},
        '{'{3, -3, 32'hC000_0000, 1},  1'b0, '0},
        '{'{3, -3, HOME, TOP},       1'b0, '0},
        '{'{3, -3, 12345, -54321},   1'b0, '0},
        '{'{3, -3, -1, BOT},         1'b0, '0},
        '{'{3, -3, TOP, TOP},        1'b0, '0},
        '{'{3, -3, BOT, BOT},        1'b0, '0},
        '{'{3, -3, 0, 0},            1'b0, '0},
        '{'{-1, -1, 0, 0},           1'b0, '0}
    };

    localparam t_cnt PHASE_CAP [PHASE_N] = '{
        6'd63, 6'd3, 6'd0, 6'd63, 6'd40, 6'd1, 6'd35, 6'd62, 6'd7, 6'd20
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;

    swpf_in_if  #(.COORD_WIDTH(CW)) in_ch ();
    swpf_out_if #(.COORD_WIDTH(CW)) out_ch ();

    staleness_weighted_position_fusion dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 clk = ~clk;

    t_fusion pending_fusions [$];
    t_pair   prev_pair;
    t_cnt    radar_cnt;
    t_cnt    laser_cnt;
    t_cnt    cap_now;
    int      errors        = 0;
    int      quiet_cycles  = 0;
    bit      no_gaps       = 1'b0;
    bit      hold_sink_req = 1'b0;

    function automatic t_cnt bump_count(t_cnt cnt, bit repeated);
        if (!repeated)
            return '0;
        if (cnt >= cap_now)
            return cap_now;
        return cnt + 1'b1;
    endfunction

    function automatic logic signed [CW-1:0] weighted_mean(longint fresh, longint stale,
                                                           int unsigned d);
        longint den, diff, q, r, s;
        if (d > CW + 2)
            d = CW + 2;
        den  = (longint'(1) << d) + 1;
        diff = stale - fresh;
        q    = diff / den;
        r    = diff % den;
        if (r < 0) begin
            q = q - 1;
            r = r + den;
        end
        s = fresh + q;
        if (s < 0 && r != 0)
            s = s + 1;
        return s[CW-1:0];
    endfunction

    function automatic t_fusion fuse_predict(t_pair p);
        t_fusion     f;
        int unsigned d;
        radar_cnt = bump_count(radar_cnt, p.radar_x == prev_pair.radar_x &&
                                          p.radar_y == prev_pair.radar_y);
        laser_cnt = bump_count(laser_cnt, p.laser_x == prev_pair.laser_x &&
                                          p.laser_y == prev_pair.laser_y);
        prev_pair = p;
        if (radar_cnt <= laser_cnt) begin
            d = int'(laser_cnt - radar_cnt);
            f.fused_x = weighted_mean(p.radar_x, p.laser_x, d);
            f.fused_y = weighted_mean(p.radar_y, p.laser_y, d);
        end else begin
            d = int'(radar_cnt - laser_cnt);
            f.fused_x = weighted_mean(p.laser_x, p.radar_x, d);
            f.fused_y = weighted_mean(p.laser_y, p.radar_y, d);
        end
        if (radar_cnt < laser_cnt) begin
            f.switched_x = p.radar_x;
            f.switched_y = p.radar_y;
        end else begin
            f.switched_x = p.laser_x;
            f.switched_y = p.laser_y;
        end
        f.radar_stale = radar_cnt;
        f.laser_stale = laser_cnt;
        return f;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(logic signed [CW-1:0] old);
        case ($urandom_range(0, 9))
            0: return TOP;
            1: return BOT;
            2: return '0;
            3: return '1;
            4: return CW'(int'($urandom_range(0, 200)) - 100);
            5: return old;
            default: return CW'($urandom());
        endcase
    endfunction

    function automatic int run_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(30, 90);
        return $urandom_range(0, 6);
    endfunction

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic push_item(input t_pair p, input bit typed, input t_fusion typed_want,
                             input int gap);
        t_fusion f;
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.radar_x <= p.radar_x;
        in_ch.radar_y <= p.radar_y;
        in_ch.laser_x <= p.laser_x;
        in_ch.laser_y <= p.laser_y;
        do @(posedge clk); while (!in_ch.ready);
        f = fuse_predict(p);
        pending_fusions.insert(pending_fusions.size(), typed ? typed_want : f);
    endtask

    task automatic rest_input();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic set_stale_cap(input t_cnt value);
        rest_input();
        wait (pending_fusions.size() == 0);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_now = value;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin
        t_pair gen_pair;
        t_pair pair;
        int    radar_left;
        int    laser_left;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.radar_x <= '0;
        in_ch.radar_y <= '0;
        in_ch.laser_x <= '0;
        in_ch.laser_y <= '0;
        prev_pair = '{HOME, HOME, HOME, HOME};
        radar_cnt = '0;
        laser_cnt = '0;
        cap_now   = SWPF_CAP_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            push_item(DIRECTED[i].pair, DIRECTED[i].typed, DIRECTED[i].want, draw_gap());

        gen_pair   = DIRECTED[ROW_N-1].pair;
        radar_left = 70;
        laser_left = 0;
        for (int ph = 0; ph < PHASE_N; ph++) begin
            set_stale_cap(PHASE_CAP[ph]);
            no_gaps = (ph % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == 20)
                    hold_sink_req = 1'b1;
                if (ph == 1 && k == 30) begin
                    rest_input();
                    wait (pending_fusions.size() == 0);
                end
                if (ph != 0 && $urandom_range(0, 9) == 0) begin
                    pair.radar_x = $urandom();
                    pair.radar_y = $urandom();
                    pair.laser_x = $urandom();
                    pair.laser_y = $urandom();
                end else begin
                    if (radar_left > 0) begin
                        radar_left--;
                    end else begin
                        gen_pair.radar_x = rand_coord(gen_pair.radar_x);
                        gen_pair.radar_y = rand_coord(gen_pair.radar_y);
                        radar_left = run_length();
                    end
                    if (laser_left > 0) begin
                        laser_left--;
                    end else begin
                        gen_pair.laser_x = rand_coord(gen_pair.laser_x);
                        gen_pair.laser_y = rand_coord(gen_pair.laser_y);
                        laser_left = run_length();
                    end
                    pair = gen_pair;
                end
                push_item(pair, 1'b0, '0, draw_gap());
            end
        end

        rest_input();
        wait (pending_fusions.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("staleness_weighted_position_fusion: match");
        else
            $display("staleness_weighted_position_fusion: mismatch");
        $finish;
    end

    initial begin
        int      stall;
        t_fusion want;

        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_sink_req) begin
                stall = SINK_HOLD;
                hold_sink_req = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            if (pending_fusions.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                want = pending_fusions.pop_front();
                check_field("fused_x", want.fused_x, out_ch.fused_x);
                check_field("fused_y", want.fused_y, out_ch.fused_y);
                check_field("switched_x", want.switched_x, out_ch.switched_x);
                check_field("switched_y", want.switched_y, out_ch.switched_y);
                check_field("radar_stale", want.radar_stale, out_ch.radar_stale);
                check_field("laser_stale", want.laser_stale, out_ch.laser_stale);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("staleness_weighted_position_fusion: mismatch");
            $finish;
        end
    end

endmodule
